/* design/rvie_pkg.sv */
package rvie_pkg;

    // field widths of one instruction and one result
    localparam int OP_W       = 4;
    localparam int KIND_W     = 2;
    localparam int DATA_W     = 64;
    localparam int DST_W      = 6;
    localparam int BR_TGT_W   = 16;
    localparam int SYS_ID_W   = 8;

    // opcodes
    localparam logic [OP_W-1:0] OP_NOP       = 4'd0;
    localparam logic [OP_W-1:0] OP_JMP       = 4'd1;
    localparam logic [OP_W-1:0] OP_MOV       = 4'd2;
    localparam logic [OP_W-1:0] OP_ADD       = 4'd3;
    localparam logic [OP_W-1:0] OP_SUB       = 4'd4;
    localparam logic [OP_W-1:0] OP_NEG       = 4'd5;
    localparam logic [OP_W-1:0] OP_SNAPSAVE  = 4'd6;
    localparam logic [OP_W-1:0] OP_SNAPSWAP  = 4'd7;
    localparam logic [OP_W-1:0] OP_SNAPCLEAR = 4'd8;
    localparam logic [OP_W-1:0] OP_REGSCLEAR = 4'd9;
    localparam logic [OP_W-1:0] OP_JZ        = 4'd10;
    localparam logic [OP_W-1:0] OP_JNZ       = 4'd11;
    localparam logic [OP_W-1:0] OP_JG        = 4'd12;
    localparam logic [OP_W-1:0] OP_JL        = 4'd13;
    localparam logic [OP_W-1:0] OP_HALT      = 4'd14;
    localparam logic [OP_W-1:0] OP_SYS       = 4'd15;

    // operand kinds (anything but a register index reads as the value itself)
    localparam logic [KIND_W-1:0] KIND_IMM   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_REG   = 2'd1;
    localparam logic [KIND_W-1:0] KIND_LABEL = 2'd2;

    // where a logical register currently lives
    typedef logic [1:0] t_loc;
    localparam t_loc LOC_ZERO = 2'd0;
    localparam t_loc LOC_P0   = 2'd1;
    localparam t_loc LOC_P1   = 2'd2;

    typedef struct packed {
        logic [OP_W-1:0]          req_type;
        logic [KIND_W-1:0]        first_kind;
        logic signed [DATA_W-1:0] first_value;
        logic [KIND_W-1:0]        second_kind;
        logic signed [DATA_W-1:0] second_value;
        logic [DST_W-1:0]         dst_reg;
    } t_req;

    typedef struct packed {
        logic                     reg_written;
        logic [DST_W-1:0]         written_reg;
        logic signed [DATA_W-1:0] written_value;
        logic                     branch_taken;
        logic [BR_TGT_W-1:0]      branch_target;
        logic                     halted;
        logic                     syscall_valid;
        logic [SYS_ID_W-1:0]      sys_code;
    } t_rsp;

    // stage enables for the index reduction pipe
    typedef struct packed {
        logic fold_en;
        logic quot_en;
    } t_pipe_en;

endpackage

/* design/rvie_req_if.sv */
interface rvie_req_if;
    import rvie_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [OP_W-1:0]          req_type;
    logic [KIND_W-1:0]        first_kind;
    logic signed [DATA_W-1:0] first_value;
    logic [KIND_W-1:0]        second_kind;
    logic signed [DATA_W-1:0] second_value;
    logic [DST_W-1:0]         dst_reg;

    modport source (
        output valid, req_type, first_kind, first_value, second_kind, second_value, dst_reg,
        input  ready
    );

    modport sink (
        input  valid, req_type, first_kind, first_value, second_kind, second_value, dst_reg,
        output ready
    );

endinterface

/* design/rvie_rsp_if.sv */
interface rvie_rsp_if;
    import rvie_pkg::*;

    logic                     valid;
    logic                     ready;
    logic                     reg_written;
    logic [DST_W-1:0]         written_reg;
    logic signed [DATA_W-1:0] written_value;
    logic                     branch_taken;
    logic [BR_TGT_W-1:0]      branch_target;
    logic                     halted;
    logic                     syscall_valid;
    logic [SYS_ID_W-1:0]      sys_code;

    modport source (
        output valid, reg_written, written_reg, written_value, branch_taken, branch_target,
               halted, syscall_valid, sys_code,
        input  ready
    );

    modport sink (
        input  valid, reg_written, written_reg, written_value, branch_taken, branch_target,
               halted, syscall_valid, sys_code,
        output ready
    );

endinterface

/* design/rvie_idx_mod.sv */
module rvie_idx_mod #(
    parameter int NUM_REGS = 64
) (
    input  logic                        i_clk,
    input  rvie_pkg::t_pipe_en          i_en,
    input  logic [63:0]                 i_value,
    output logic [$clog2(NUM_REGS)-1:0] o_index
);
    import rvie_pkg::*;

    localparam int IW     = $clog2(NUM_REGS);
    localparam int NBYTES = DATA_W / 8;
    // eight bytes times residues below 256 stay under 2^19
    localparam int FOLD_W = 19;
    localparam int PROD_W = 2 * FOLD_W;
    localparam logic [FOLD_W-1:0] MODULUS = FOLD_W'(NUM_REGS);
    localparam logic [FOLD_W-1:0] RECIP   = FOLD_W'((1 << FOLD_W) / NUM_REGS);

    // residues of 2^(8j) modulo the register count, one byte each
    function automatic logic [DATA_W-1:0] fold_consts();
        logic [DATA_W-1:0] c;
        int unsigned       p;
        c = '0;
        p = 1;
        for (int j = 0; j < NBYTES; j++) begin
            c[8*j +: 8] = 8'(p);
            for (int k = 0; k < 8; k++) begin
                p = p * 2;
                if (p >= NUM_REGS) begin
                    p = p - NUM_REGS;
                end
            end
        end
        return c;
    endfunction

    localparam logic [DATA_W-1:0] FOLD_C = fold_consts();

    logic [FOLD_W-1:0] n_fold;
    logic [FOLD_W-1:0] r_fold;
    logic [PROD_W-1:0] w_prod;
    logic [FOLD_W-1:0] n_quot;
    logic [FOLD_W-1:0] r_quot;
    logic [FOLD_W-1:0] r_x;
    logic [FOLD_W-1:0] w_qn;
    logic [FOLD_W-1:0] w_rem;
    logic [FOLD_W-1:0] w_rem_fix;

    // byte fold: weighted sum of bytes keeps the residue
    always_comb begin
        n_fold = '0;
        for (int j = 0; j < NBYTES; j++) begin
            n_fold = n_fold + FOLD_W'(i_value[8*j +: 8]) * FOLD_W'(FOLD_C[8*j +: 8]);
        end
    end

    // quotient estimate by reciprocal, at most one short
    assign w_prod = PROD_W'(r_fold) * PROD_W'(RECIP);
    assign n_quot = w_prod[FOLD_W +: FOLD_W];

    always_ff @(posedge i_clk) begin
        if (i_en.fold_en) begin
            r_fold <= n_fold;
        end
        if (i_en.quot_en) begin
            r_quot <= n_quot;
            r_x    <= r_fold;
        end
    end

    // remainder with one correction step
    assign w_qn      = FOLD_W'(r_quot * MODULUS);
    assign w_rem     = r_x - w_qn;
    assign w_rem_fix = (w_rem >= MODULUS) ? (w_rem - MODULUS) : w_rem;
    assign o_index   = IW'(w_rem_fix);

endmodule

/* design/rvie_regmem.sv */
module rvie_regmem #(
    parameter int DEPTH = 64
) (
    input  logic                        i_clk,
    input  logic                        i_rd_en,
    input  logic [$clog2(DEPTH)-1:0]    i_rd_addr_a,
    input  logic [$clog2(DEPTH)-1:0]    i_rd_addr_b,
    output logic [rvie_pkg::DATA_W-1:0] o_rd_data_a,
    output logic [rvie_pkg::DATA_W-1:0] o_rd_data_b,
    input  logic                        i_wr_en,
    input  logic [$clog2(DEPTH)-1:0]    i_wr_addr,
    input  logic [rvie_pkg::DATA_W-1:0] i_wr_data
);
    import rvie_pkg::*;

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_a;
    logic [DATA_W-1:0] r_rd_b;

    // one write port, two registered read ports (old data on a clash)
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_a <= r_mem[i_rd_addr_a];
            r_rd_b <= r_mem[i_rd_addr_b];
        end
    end

    assign o_rd_data_a = r_rd_a;
    assign o_rd_data_b = r_rd_b;

endmodule

/* design/register_vm_instruction_executor.sv */
// Executes one decoded VM instruction per transfer and returns one result per
// instruction, in order. A new instruction is taken every clock as long as
// results are taken; each result passes through five pipeline registers:
// input, two stages that reduce the register indices modulo NUM_REGS, the
// registered read of the register storage, and the result register. The
// working and snapshot banks are held as two physical RAMs of NUM_REGS
// entries plus a two-bit location tag per logical register, so snapshot
// save, swap and the two bank clears only rewrite tags, with no clearing
// sweep; the register file reads as all zero straight after reset.
// Back-to-back dependent instructions see each other's writes through a
// one-entry bypass on the RAM read.
module register_vm_instruction_executor #(
    parameter int NUM_REGS = 64,
    parameter int PC_BITS  = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rvie_req_if.sink    i_req,
    rvie_rsp_if.source  o_rsp
);
    import rvie_pkg::*;

    localparam int IW    = $clog2(NUM_REGS);
    localparam int TGT_W = (PC_BITS < BR_TGT_W) ? PC_BITS : BR_TGT_W;

    // pipeline handshake
    logic rdy0, rdy1, rdy2, rdy3, rdy4;
    logic adv1, adv2, adv3, adv4;
    logic acc;
    logic r_v0, r_v1, r_v2, r_v3, r_v4;

    // payload per stage
    t_req r_s0, r_s1, r_s2, r_s3;
    t_rsp n_rsp, r_rsp;

    // reduced indices
    t_pipe_en          pipe_en;
    logic [IW-1:0]     w_ix1, w_ix2, w_ixd;
    logic [IW-1:0]     r_ix1, r_ix2, r_ixd;

    // bank read data
    logic [DATA_W-1:0] rd0_a, rd0_b, rd1_a, rd1_b;

    // location tags and bank role
    t_loc [NUM_REGS-1:0] r_map_a, r_map_b, n_map_a, n_map_b;
    logic                r_active, n_active;

    // write bypass
    logic              r_fwd_v;
    t_loc              r_fwd_loc;
    logic [IW-1:0]     r_fwd_ix;
    logic [DATA_W-1:0] r_fwd_val;

    // execute stage
    t_loc              wloc1, wloc2, sloc_d, wr_loc;
    logic              hit1, hit2;
    logic [DATA_W-1:0] reg1, reg2, opnd1, opnd2;
    logic              e_wr, e_br;
    logic [DATA_W-1:0] e_wval, e_tgt;
    logic              we0, we1;

    function automatic logic [DATA_W-1:0] pick_reg(
        t_loc              loc,
        logic              hit,
        logic [DATA_W-1:0] fwd,
        logic [DATA_W-1:0] d0,
        logic [DATA_W-1:0] d1
    );
        logic [DATA_W-1:0] v;
        unique case (loc)
            LOC_P0:  v = hit ? fwd : d0;
            LOC_P1:  v = hit ? fwd : d1;
            default: v = '0;
        endcase
        return v;
    endfunction

    // ready chain from the result side back to the input
    assign rdy4 = !r_v4 || o_rsp.ready;
    assign adv4 = r_v3 && rdy4;
    assign rdy3 = !r_v3 || rdy4;
    assign adv3 = r_v2 && rdy3;
    assign rdy2 = !r_v2 || rdy3;
    assign adv2 = r_v1 && rdy2;
    assign rdy1 = !r_v1 || rdy2;
    assign adv1 = r_v0 && rdy1;
    assign rdy0 = !r_v0 || rdy1;
    assign acc  = i_req.valid && rdy0;

    assign i_req.ready = rdy0;

    // stage valid flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v0 <= acc  || (r_v0 && !adv1);
            r_v1 <= adv1 || (r_v1 && !adv2);
            r_v2 <= adv2 || (r_v2 && !adv3);
            r_v3 <= adv3 || (r_v3 && !adv4);
            r_v4 <= adv4 || (r_v4 && !o_rsp.ready);
        end
    end

    // instruction payload moves with its stage
    always_ff @(posedge i_clk) begin
        if (acc) begin
            r_s0.req_type     <= i_req.req_type;
            r_s0.first_kind   <= i_req.first_kind;
            r_s0.first_value  <= i_req.first_value;
            r_s0.second_kind  <= i_req.second_kind;
            r_s0.second_value <= i_req.second_value;
            r_s0.dst_reg      <= i_req.dst_reg;
        end
        if (adv1) begin
            r_s1 <= r_s0;
        end
        if (adv2) begin
            r_s2 <= r_s1;
        end
        if (adv3) begin
            r_s3  <= r_s2;
            r_ix1 <= w_ix1;
            r_ix2 <= w_ix2;
            r_ixd <= w_ixd;
        end
        if (adv4) begin
            r_rsp <= n_rsp;
        end
    end

    // index reduction for both operands and the destination
    assign pipe_en.fold_en = adv1;
    assign pipe_en.quot_en = adv2;

    rvie_idx_mod #(.NUM_REGS(NUM_REGS)) u_mod_first (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_value (r_s0.first_value),
        .o_index (w_ix1)
    );

    rvie_idx_mod #(.NUM_REGS(NUM_REGS)) u_mod_second (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_value (r_s0.second_value),
        .o_index (w_ix2)
    );

    rvie_idx_mod #(.NUM_REGS(NUM_REGS)) u_mod_dst (
        .i_clk   (i_clk),
        .i_en    (pipe_en),
        .i_value (DATA_W'(r_s0.dst_reg)),
        .o_index (w_ixd)
    );

    // physical register storage
    rvie_regmem #(.DEPTH(NUM_REGS)) u_bank0 (
        .i_clk       (i_clk),
        .i_rd_en     (adv3),
        .i_rd_addr_a (w_ix1),
        .i_rd_addr_b (w_ix2),
        .o_rd_data_a (rd0_a),
        .o_rd_data_b (rd0_b),
        .i_wr_en     (we0),
        .i_wr_addr   (r_ixd),
        .i_wr_data   (e_wval)
    );

    rvie_regmem #(.DEPTH(NUM_REGS)) u_bank1 (
        .i_clk       (i_clk),
        .i_rd_en     (adv3),
        .i_rd_addr_a (w_ix1),
        .i_rd_addr_b (w_ix2),
        .o_rd_data_a (rd1_a),
        .o_rd_data_b (rd1_b),
        .i_wr_en     (we1),
        .i_wr_addr   (r_ixd),
        .i_wr_data   (e_wval)
    );

    // operand fetch through the location tags and the bypass
    assign wloc1  = r_active ? r_map_b[r_ix1] : r_map_a[r_ix1];
    assign wloc2  = r_active ? r_map_b[r_ix2] : r_map_a[r_ix2];
    assign sloc_d = r_active ? r_map_a[r_ixd] : r_map_b[r_ixd];
    assign hit1   = r_fwd_v && (r_fwd_ix == r_ix1) && (r_fwd_loc == wloc1);
    assign hit2   = r_fwd_v && (r_fwd_ix == r_ix2) && (r_fwd_loc == wloc2);
    assign reg1   = pick_reg(wloc1, hit1, r_fwd_val, rd0_a, rd1_a);
    assign reg2   = pick_reg(wloc2, hit2, r_fwd_val, rd0_b, rd1_b);
    assign opnd1  = (r_s3.first_kind == KIND_REG) ? reg1 : r_s3.first_value;
    assign opnd2  = (r_s3.second_kind == KIND_REG) ? reg2 : r_s3.second_value;

    // a write goes to whichever physical copy the snapshot is not using
    assign wr_loc = (sloc_d == LOC_P0) ? LOC_P1 : LOC_P0;
    assign we0    = adv4 && e_wr && (wr_loc == LOC_P0);
    assign we1    = adv4 && e_wr && (wr_loc == LOC_P1);

    // execute
    always_comb begin
        n_rsp  = '0;
        e_wr   = 1'b0;
        e_br   = 1'b0;
        e_wval = '0;
        e_tgt  = opnd2;
        unique case (r_s3.req_type)
            OP_NOP, OP_SNAPSAVE, OP_SNAPSWAP, OP_SNAPCLEAR, OP_REGSCLEAR: begin
            end
            OP_JMP: begin
                e_br  = 1'b1;
                e_tgt = opnd1;
            end
            OP_MOV: begin
                e_wr   = 1'b1;
                e_wval = opnd1;
            end
            OP_ADD: begin
                e_wr   = 1'b1;
                e_wval = opnd1 + opnd2;
            end
            OP_SUB: begin
                e_wr   = 1'b1;
                e_wval = opnd1 - opnd2;
            end
            OP_NEG: begin
                e_wr   = 1'b1;
                e_wval = '0 - reg1;
            end
            OP_JZ: begin
                e_br = (opnd1 == '0);
            end
            OP_JNZ: begin
                e_br = (opnd1 != '0);
            end
            OP_JG: begin
                e_br = (opnd1 != '0) && !opnd1[DATA_W-1];
            end
            OP_JL: begin
                e_br = opnd1[DATA_W-1];
            end
            OP_HALT: begin
                n_rsp.halted = 1'b1;
            end
            OP_SYS: begin
                n_rsp.syscall_valid = 1'b1;
                n_rsp.sys_code      = r_s3.first_value[SYS_ID_W-1:0];
            end
        endcase
        n_rsp.reg_written   = e_wr;
        n_rsp.written_reg   = e_wr ? DST_W'(r_ixd) : '0;
        n_rsp.written_value = e_wr ? e_wval : '0;
        n_rsp.branch_taken  = e_br;
        n_rsp.branch_target = e_br ? BR_TGT_W'(e_tgt[TGT_W-1:0]) : '0;
    end

    // bank bookkeeping: copies and clears only move the tags
    always_comb begin
        n_map_a  = r_map_a;
        n_map_b  = r_map_b;
        n_active = r_active;
        if (adv4) begin
            unique case (r_s3.req_type)
                OP_SNAPSAVE: begin
                    if (r_active) begin
                        n_map_a = r_map_b;
                    end else begin
                        n_map_b = r_map_a;
                    end
                end
                OP_SNAPSWAP: begin
                    n_active = !r_active;
                end
                OP_SNAPCLEAR: begin
                    if (r_active) begin
                        n_map_a = '0;
                    end else begin
                        n_map_b = '0;
                    end
                end
                OP_REGSCLEAR: begin
                    if (r_active) begin
                        n_map_b = '0;
                    end else begin
                        n_map_a = '0;
                    end
                end
                default: begin
                    if (e_wr) begin
                        if (r_active) begin
                            n_map_b[r_ixd] = wr_loc;
                        end else begin
                            n_map_a[r_ixd] = wr_loc;
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_map_a  <= '0;
            r_map_b  <= '0;
            r_active <= 1'b0;
        end else begin
            r_map_a  <= n_map_a;
            r_map_b  <= n_map_b;
            r_active <= n_active;
        end
    end

    // bypass the write that lands on the same edge as the bank read
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd_v <= 1'b0;
        end else if (adv3) begin
            r_fwd_v <= adv4 && e_wr;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv3) begin
            r_fwd_loc <= wr_loc;
            r_fwd_ix  <= r_ixd;
            r_fwd_val <= e_wval;
        end
    end

    // result port
    assign o_rsp.valid         = r_v4;
    assign o_rsp.reg_written   = r_rsp.reg_written;
    assign o_rsp.written_reg   = r_rsp.written_reg;
    assign o_rsp.written_value = r_rsp.written_value;
    assign o_rsp.branch_taken  = r_rsp.branch_taken;
    assign o_rsp.branch_target = r_rsp.branch_target;
    assign o_rsp.halted        = r_rsp.halted;
    assign o_rsp.syscall_valid = r_rsp.syscall_valid;
    assign o_rsp.sys_code      = r_rsp.sys_code;

    // checks
    a_one_effect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> $onehot0({o_rsp.reg_written, o_rsp.branch_taken,
                                  o_rsp.halted, o_rsp.syscall_valid}))
        else $error("result reports more than one effect");

    a_snapsave: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv4 && (r_s3.req_type == OP_SNAPSAVE)) |=> (r_map_a == r_map_b))
        else $error("snapshot does not match working bank after save");

    a_regsclear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv4 && (r_s3.req_type == OP_REGSCLEAR)) |=>
            ((r_active ? r_map_b : r_map_a) == '0))
        else $error("working bank not clear after register clear");

    a_snapswap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (adv4 && (r_s3.req_type == OP_SNAPSWAP)) |=> (r_active != $past(r_active)))
        else $error("bank roles not swapped");

endmodule

/* dv/rvie_exec_check.sv */
module rvie_exec_check (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_end_of_test,
    rvie_req_if  i_req_mon,
    rvie_rsp_if  i_rsp_mon,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked,
    output int   o_branches
);
    timeunit 1ns;
    timeprecision 1ps;

    import rvie_pkg::*;

    localparam int NUM_REGS = 64;
    localparam int PC_BITS  = 16;
    localparam int IDX_W    = $clog2(NUM_REGS);
    localparam logic [DATA_W-1:0] PC_MASK = (64'd1 << PC_BITS) - 64'd1;
    localparam int PRINT_CAP = 30;

    // shadow of the two register files and of which one is working
    logic [DATA_W-1:0] file_a [NUM_REGS];
    logic [DATA_W-1:0] file_b [NUM_REGS];
    logic              b_is_working;

    t_rsp outstanding_results [$];
    t_req seen_req;
    t_rsp seen_rsp;
    int   fail_total;
    int   checked_total;
    int   branch_total;
    bit   leftovers_checked;

    function automatic logic [IDX_W-1:0] slot_of(logic [DATA_W-1:0] v);
        return IDX_W'(v % NUM_REGS);
    endfunction

    function automatic logic [DATA_W-1:0] working_reg(logic [IDX_W-1:0] idx);
        return b_is_working ? file_b[idx] : file_a[idx];
    endfunction

    // register index kinds read the working file, every other kind is the value itself
    function automatic logic [DATA_W-1:0] operand_value(logic [KIND_W-1:0] kind,
                                                        logic [DATA_W-1:0] v);
        return (kind == KIND_REG) ? working_reg(slot_of(v)) : v;
    endfunction

    // run one instruction on the shadow state and return what it must report
    function automatic t_rsp execute_instr(t_req r);
        t_rsp              res;
        logic [DATA_W-1:0] lhs;
        logic [DATA_W-1:0] rhs;
        logic [DATA_W-1:0] val;
        logic [IDX_W-1:0]  dst;
        logic              taken;
        res   = '0;
        val   = '0;
        taken = 1'b0;
        dst   = IDX_W'(r.dst_reg % NUM_REGS);
        lhs   = operand_value(r.first_kind, r.first_value);
        rhs   = operand_value(r.second_kind, r.second_value);
        case (r.req_type)
            OP_JMP: begin
                res.branch_taken  = 1'b1;
                res.branch_target = BR_TGT_W'(lhs & PC_MASK);
            end
            OP_MOV: begin
                res.reg_written = 1'b1;
                val = lhs;
            end
            OP_ADD: begin
                res.reg_written = 1'b1;
                val = lhs + rhs;
            end
            OP_SUB: begin
                res.reg_written = 1'b1;
                val = lhs - rhs;
            end
            OP_NEG: begin
                // source is always a register, whatever the operand kind says
                res.reg_written = 1'b1;
                val = '0 - working_reg(slot_of(r.first_value));
            end
            OP_SNAPSAVE: begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    if (b_is_working) file_a[i] = file_b[i];
                    else              file_b[i] = file_a[i];
                end
            end
            OP_SNAPSWAP: begin
                b_is_working = !b_is_working;
            end
            OP_SNAPCLEAR: begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    if (b_is_working) file_a[i] = '0;
                    else              file_b[i] = '0;
                end
            end
            OP_REGSCLEAR: begin
                for (int i = 0; i < NUM_REGS; i++) begin
                    if (b_is_working) file_b[i] = '0;
                    else              file_a[i] = '0;
                end
            end
            OP_JZ, OP_JNZ, OP_JG, OP_JL: begin
                case (r.req_type)
                    OP_JZ:   taken = (lhs == '0);
                    OP_JNZ:  taken = (lhs != '0);
                    OP_JG:   taken = (lhs != '0) && !lhs[DATA_W-1];
                    default: taken = lhs[DATA_W-1];
                endcase
                if (taken) begin
                    res.branch_taken  = 1'b1;
                    res.branch_target = BR_TGT_W'(rhs & PC_MASK);
                end
            end
            OP_HALT: begin
                res.halted = 1'b1;
            end
            OP_SYS: begin
                res.syscall_valid = 1'b1;
                res.sys_code      = r.first_value[SYS_ID_W-1:0];
            end
            default: begin
            end
        endcase
        if (res.reg_written) begin
            res.written_reg   = dst;
            res.written_value = val;
            if (b_is_working) file_b[dst] = val;
            else              file_a[dst] = val;
        end
        return res;
    endfunction

    // one line per failure, log kept short on a badly broken block
    task automatic report_mismatch(string msg);
        if (fail_total < PRINT_CAP)
            $display("[%0t] mismatch: %s", $time, msg);
        fail_total++;
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] got, logic [DATA_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("result %0d %s is %h, expected %h",
                                      checked_total, name, got, want));
    endtask

    task automatic compare_result(t_rsp got);
        t_rsp want;
        if (outstanding_results.size() == 0) begin
            report_mismatch($sformatf("result %0d arrived with no instruction outstanding",
                                      checked_total));
            return;
        end
        want = outstanding_results.pop_front();
        check_field("reg_written",   got.reg_written,   want.reg_written);
        check_field("written_reg",   got.written_reg,   want.written_reg);
        check_field("written_value", got.written_value, want.written_value);
        check_field("branch_taken",  got.branch_taken,  want.branch_taken);
        check_field("branch_target", got.branch_target, want.branch_target);
        check_field("halted",        got.halted,        want.halted);
        check_field("syscall_valid", got.syscall_valid, want.syscall_valid);
        check_field("sys_code",      got.sys_code,      want.sys_code);
    endtask

    // watch both channels, predict on each instruction transfer, compare on each result
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < NUM_REGS; i++) begin
                file_a[i] = '0;
                file_b[i] = '0;
            end
            b_is_working = 1'b0;
            outstanding_results.delete();
        end else begin
            if (i_rsp_mon.valid && i_rsp_mon.ready) begin
                seen_rsp.reg_written   = i_rsp_mon.reg_written;
                seen_rsp.written_reg   = i_rsp_mon.written_reg;
                seen_rsp.written_value = i_rsp_mon.written_value;
                seen_rsp.branch_taken  = i_rsp_mon.branch_taken;
                seen_rsp.branch_target = i_rsp_mon.branch_target;
                seen_rsp.halted        = i_rsp_mon.halted;
                seen_rsp.syscall_valid = i_rsp_mon.syscall_valid;
                seen_rsp.sys_code      = i_rsp_mon.sys_code;
                compare_result(seen_rsp);
                checked_total++;
            end
            if (i_req_mon.valid && i_req_mon.ready) begin
                seen_req.req_type     = i_req_mon.req_type;
                seen_req.first_kind   = i_req_mon.first_kind;
                seen_req.first_value  = i_req_mon.first_value;
                seen_req.second_kind  = i_req_mon.second_kind;
                seen_req.second_value = i_req_mon.second_value;
                seen_req.dst_reg      = i_req_mon.dst_reg;
                seen_rsp = execute_instr(seen_req);
                if (seen_rsp.branch_taken) branch_total++;
                outstanding_results = {outstanding_results, seen_rsp};
            end
            if (i_end_of_test && !leftovers_checked) begin
                leftovers_checked = 1'b1;
                if (outstanding_results.size() != 0)
                    report_mismatch($sformatf("%0d results never arrived",
                                              outstanding_results.size()));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= outstanding_results.size();
        o_checked    <= checked_total;
        o_branches   <= branch_total;
    end

endmodule

/* dv/tb_register_vm_instruction_executor.sv */
module tb_register_vm_instruction_executor;
    timeunit 1ns;
    timeprecision 1ps;

    import rvie_pkg::*;

    localparam int          RANDOM_ITEMS = 1225;
    localparam int          CYCLE_LIMIT  = 120000;
    localparam int          DRAIN_LIMIT  = 2000;
    localparam int          TAIL_CYCLES  = 12;
    localparam int unsigned HOLD_CYCLES  = 120;

    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
    localparam logic [DATA_W-1:0] MAX_S64     = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [DATA_W-1:0] MIN_S64     = 64'h8000_0000_0000_0000;
    localparam logic [DATA_W-1:0] ALL_ONES    = '1;

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic end_of_test;

    bit          sender_quiet   = 1'b0;
    bit          receiver_quiet = 1'b0;
    int          hold_requests  = 0;
    int          holds_done     = 0;
    int          issued         = 0;
    int unsigned longest_stall  = 0;
    int          cycle_count    = 0;
    bit          op_seen [16];

    int fail_count;
    int pending;
    int checked;
    int branches;

    rvie_req_if req_if ();
    rvie_rsp_if rsp_if ();

    register_vm_instruction_executor dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if),
        .o_rsp   (rsp_if)
    );

    rvie_exec_check u_exec_check (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_end_of_test (end_of_test),
        .i_req_mon     (req_if),
        .i_rsp_mon     (rsp_if),
        .o_fail_count  (fail_count),
        .o_pending     (pending),
        .o_checked     (checked),
        .o_branches    (branches)
    );

    // 4 ns clock
    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    // run limit
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    function automatic t_req make_instr(logic [OP_W-1:0] op,
                                        logic [KIND_W-1:0] k1, logic [DATA_W-1:0] v1,
                                        logic [KIND_W-1:0] k2, logic [DATA_W-1:0] v2,
                                        logic [DST_W-1:0] dst);
        t_req r;
        r.req_type     = op;
        r.first_kind   = k1;
        r.first_value  = v1;
        r.second_kind  = k2;
        r.second_value = v2;
        r.dst_reg      = dst;
        return r;
    endfunction

    // data values lean on the edges of the signed range
    function automatic logic [DATA_W-1:0] rand_data();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return ALL_ONES;
            2:       return MAX_S64;
            3:       return MIN_S64;
            4:       return 64'($urandom_range(0, 255));
            5:       return '0 - 64'($urandom_range(1, 255));
            default: return {$urandom, $urandom};
        endcase
    endfunction

    function automatic logic [KIND_W-1:0] rand_kind();
        int unsigned p;
        p = $urandom_range(0, 19);
        if (p < 10)      return KIND_REG;
        else if (p < 16) return KIND_IMM;
        else if (p < 19) return KIND_LABEL;
        else             return KIND_UNUSED;
    endfunction

    // register indices mostly in a small set so instructions depend on each other
    function automatic logic [DATA_W-1:0] rand_operand(logic [KIND_W-1:0] kind);
        if (kind == KIND_REG) begin
            case ($urandom_range(0, 3))
                0:       return {$urandom, $urandom};
                1:       return 64'($urandom_range(0, 7));
                2:       return 64'($urandom_range(56, 63));
                default: return 64'($urandom_range(0, 11));
            endcase
        end
        if (kind == KIND_LABEL && $urandom_range(0, 1) == 0)
            return 64'($urandom_range(0, 65535));
        return rand_data();
    endfunction

    // mostly register arithmetic and conditional jumps, snapshot ops and noise more rarely
    function automatic t_req random_instr();
        t_req        r;
        int unsigned pick;
        r.first_kind   = rand_kind();
        r.first_value  = rand_operand(r.first_kind);
        r.second_kind  = rand_kind();
        r.second_value = rand_operand(r.second_kind);
        r.dst_reg      = ($urandom_range(0, 3) == 0) ? DST_W'($urandom)
                                                     : DST_W'($urandom_range(0, 11));
        pick = $urandom_range(0, 99);
        if (pick < 20)      r.req_type = OP_MOV;
        else if (pick < 38) r.req_type = OP_ADD;
        else if (pick < 52) r.req_type = OP_SUB;
        else if (pick < 58) r.req_type = OP_NEG;
        else if (pick < 62) r.req_type = OP_JMP;
        else if (pick < 80) r.req_type = OP_JZ + OP_W'($urandom_range(0, 3));
        else if (pick < 83) r.req_type = OP_SNAPSAVE;
        else if (pick < 86) r.req_type = OP_SNAPSWAP;
        else if (pick < 88) r.req_type = OP_SNAPCLEAR;
        else if (pick < 89) r.req_type = OP_REGSCLEAR;
        else if (pick < 92) r.req_type = OP_HALT;
        else if (pick < 96) r.req_type = OP_SYS;
        else                r.req_type = OP_NOP;
        return r;
    endfunction

    // offer one instruction after a random gap, or none while the sender is quiet, and wait for its transfer
    task automatic send_instr(input t_req r);
        int unsigned gap;
        int unsigned waited;
        gap = sender_quiet ? 0 : $urandom_range(0, 5);
        if (gap != 0) begin
            req_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        req_if.valid        <= 1'b1;
        req_if.req_type     <= r.req_type;
        req_if.first_kind   <= r.first_kind;
        req_if.first_value  <= r.first_value;
        req_if.second_kind  <= r.second_kind;
        req_if.second_value <= r.second_value;
        req_if.dst_reg      <= r.dst_reg;
        waited = 0;
        @(posedge i_clk);
        while (!req_if.ready) begin
            waited++;
            @(posedge i_clk);
        end
        if (waited > longest_stall) longest_stall = waited;
        op_seen[r.req_type] = 1'b1;
        issued++;
    endtask

    // result side: random stalls, long hold-offs on request
    initial begin : result_sink
        int unsigned stall;
        rsp_if.ready <= 1'b0;
        do @(posedge i_clk); while (!i_rst_n);
        forever begin
            if (holds_done < hold_requests) begin
                stall = HOLD_CYCLES;
                holds_done++;
            end else begin
                stall = receiver_quiet ? 0 : $urandom_range(0, 5);
            end
            if (stall != 0) begin
                rsp_if.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_if.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_if.valid);
        end
    end

    initial begin : stimulus
        int opcodes_hit;
        i_rst_n             <= 1'b0;
        end_of_test         <= 1'b0;
        req_if.valid        <= 1'b0;
        req_if.req_type     <= OP_NOP;
        req_if.first_kind   <= KIND_IMM;
        req_if.first_value  <= '0;
        req_if.second_kind  <= KIND_IMM;
        req_if.second_value <= '0;
        req_if.dst_reg      <= '0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // directed: range edges, wrap-around, index wrap, every opcode but NOP, snapshot sequence
        send_instr(make_instr(OP_MOV, KIND_IMM, MAX_S64, KIND_IMM, 0, 6'd0));
        send_instr(make_instr(OP_MOV, KIND_LABEL, MIN_S64, KIND_IMM, 0, 6'd63));
        send_instr(make_instr(OP_ADD, KIND_REG, 0, KIND_IMM, 1, 6'd1));
        send_instr(make_instr(OP_SUB, KIND_REG, 63, KIND_REG, 64, 6'd2));
        send_instr(make_instr(OP_ADD, KIND_LABEL, 100, KIND_UNUSED, ALL_ONES, 6'd3));
        send_instr(make_instr(OP_MOV, KIND_REG, ALL_ONES, KIND_IMM, 0, 6'd4));
        send_instr(make_instr(OP_NEG, KIND_IMM, 63, KIND_IMM, 0, 6'd5));
        send_instr(make_instr(OP_NEG, KIND_LABEL, 66, KIND_IMM, 0, 6'd6));
        send_instr(make_instr(OP_JMP, KIND_IMM, 64'h1_2345, KIND_IMM, 0, 6'd0));
        send_instr(make_instr(OP_JMP, KIND_REG, 0, KIND_IMM, 0, 6'd0));
        send_instr(make_instr(OP_JZ, KIND_REG, 7, KIND_LABEL, 64'hABCD, 6'd0));
        send_instr(make_instr(OP_JZ, KIND_IMM, 5, KIND_IMM, 64'h40, 6'd0));
        send_instr(make_instr(OP_JNZ, KIND_IMM, ALL_ONES, KIND_REG, 6, 6'd0));
        send_instr(make_instr(OP_JG, KIND_IMM, MAX_S64, KIND_IMM, 64'h10, 6'd0));
        send_instr(make_instr(OP_JG, KIND_IMM, 0, KIND_IMM, 64'h11, 6'd0));
        send_instr(make_instr(OP_JL, KIND_IMM, MIN_S64, KIND_IMM, 64'h20, 6'd0));
        send_instr(make_instr(OP_SNAPSAVE, KIND_IMM, 0, KIND_IMM, 0, 6'd0));
        send_instr(make_instr(OP_REGSCLEAR, KIND_IMM, 0, KIND_IMM, 0, 6'd0));
        send_instr(make_instr(OP_MOV, KIND_REG, 0, KIND_IMM, 0, 6'd8));
        send_instr(make_instr(OP_SNAPSWAP, KIND_IMM, 0, KIND_IMM, 0, 6'd0));
        send_instr(make_instr(OP_MOV, KIND_REG, 0, KIND_IMM, 0, 6'd9));
        send_instr(make_instr(OP_SNAPCLEAR, KIND_IMM, 0, KIND_IMM, 0, 6'd0));
        send_instr(make_instr(OP_SNAPSWAP, KIND_IMM, 0, KIND_IMM, 0, 6'd0));
        send_instr(make_instr(OP_ADD, KIND_REG, 8, KIND_REG, 9, 6'd10));
        send_instr(make_instr(OP_HALT, KIND_IMM, 0, KIND_IMM, 0, 6'd0));
        send_instr(make_instr(OP_SYS, KIND_IMM, ALL_ONES, KIND_IMM, 0, 6'd63));

        // random: no idling, then idling, then result hold-offs under full input rate
        sender_quiet   = 1'b1;
        receiver_quiet = 1'b1;
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            if (n == 300) begin
                sender_quiet   = 1'b0;
                receiver_quiet = 1'b0;
            end
            if (n == 600 || n == 950) begin
                sender_quiet = 1'b1;
                hold_requests++;
            end
            if (n == 720 || n == 1070) sender_quiet = 1'b0;
            send_instr(random_instr());
        end
        req_if.valid <= 1'b0;

        // drain, then wait out a tail for anything stray
        for (int n = 0; n < DRAIN_LIMIT && pending != 0; n++) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        end_of_test <= 1'b1;
        repeat (3) @(posedge i_clk);

        opcodes_hit = 0;
        foreach (op_seen[i]) if (op_seen[i]) opcodes_hit++;
        $display("%0d instructions over %0d of 16 opcodes, %0d results compared, %0d jumps taken",
                 issued, opcodes_hit, checked, branches);
        $display("%0d result hold-offs, longest input stall %0d cycles, %0d mismatches",
                 holds_done, longest_stall, fail_count);
        if (fail_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

/* sim.f */
design/rvie_pkg.sv
design/rvie_req_if.sv
design/rvie_rsp_if.sv
design/rvie_idx_mod.sv
design/rvie_regmem.sv
design/register_vm_instruction_executor.sv
dv/rvie_exec_check.sv
dv/tb_register_vm_instruction_executor.sv
